// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define APQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define APQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// shared types and constants of the array priority queue
// ----------------------------------------------------------------------------
package apq_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 8;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

endpackage

// ===== rtl/apq_ram.sv =====
// ----------------------------------------------------------------------------
// apq_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module apq_ram #(
    parameter int ADDR_W = 7,
    parameter int WORD_W = 40
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/array_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// array_priority_queue_core
// priority queue over an unsorted array with a linear scan on dequeue
// ----------------------------------------------------------------------------
// input channel s_*: one word per command, s_opcode enqueue or dequeue,
// with s_data_value and s_priority_req used by enqueue.
// result channel m_*: exactly one word per command with status, the
// dequeued data and priority (zero otherwise) and the occupancy after it.
// entries live in one ram of DEPTH words with a registered read.
// an enqueue or a rejected command goes from IDLE straight to RESP.
// a dequeue of n held entries first scans the ram for the best priority
// in state SCAN, then makes a read/write-back pass in state SHIFT
// that moves every later entry down one place.
// a new command is taken once the previous one is finished, even while
// its result still sits in the output register.
// when the receiver stalls the finished result waits in a holding state
// and no further command is taken.
// reset empties the queue; the ram itself is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_priority_queue_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic signed [apq_pkg::DATA_W-1:0]   s_data_value,
    input  logic [apq_pkg::PRIO_W-1:0]          s_priority_req,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [apq_pkg::DATA_W-1:0]   m_out_data,
    output logic [apq_pkg::PRIO_W-1:0]          m_out_priority,
    output logic [apq_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int AW = apq_pkg::ADDR_W;
    localparam int CW = apq_pkg::CNT_W;

    apq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    sh_reg, sh_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    waddr_reg, waddr_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    apq_pkg::entry_t  best_reg, best_next;
    apq_pkg::status_t status_reg, status_next;

    logic                                m_valid_reg, m_valid_next;
    apq_pkg::status_t                    m_status_reg;
    logic signed [apq_pkg::DATA_W-1:0]   m_data_reg;
    logic [apq_pkg::PRIO_W-1:0]          m_prio_reg;
    logic [apq_pkg::OCC_W-1:0]           m_occ_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    apq_pkg::entry_t wr_data;
    logic [AW-1:0]   rd_addr;
    apq_pkg::entry_t rd_data;

    logic accept, is_enq, not_full, scan_last, sh_issue, shift_done, out_free, load_out;

    apq_ram #(
        .ADDR_W (AW),
        .WORD_W ($bits(apq_pkg::entry_t))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept     = s_valid && s_ready;
    assign is_enq     = (apq_pkg::op_t'(s_opcode) == apq_pkg::OP_ENQ);
    assign not_full   = (count_reg < CW'(apq_pkg::DEPTH));
    assign scan_last  = (idx_reg == count_reg);
    assign sh_issue   = (sh_reg < count_reg);
    assign shift_done = !sh_issue && !pend_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign load_out   = (state_reg == apq_pkg::ST_RESP) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!is_enq && count_reg != '0) begin
                        state_next = apq_pkg::ST_SCAN;
                    end else begin
                        state_next = apq_pkg::ST_RESP;
                    end
                end
            end
            apq_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = apq_pkg::ST_SHIFT;
                end
            end
            apq_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    state_next = apq_pkg::ST_RESP;
                end
            end
            apq_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = apq_pkg::ST_IDLE;
                end
            end
            default: state_next = apq_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = waddr_reg;
        wr_data       = rd_data;
        rd_addr       = idx_reg[AW-1:0];
        count_next    = count_reg;
        idx_next      = idx_reg;
        sh_next       = sh_reg;
        pend_next     = 1'b0;
        waddr_next    = waddr_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        case (state_reg)
            apq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    best_next   = '0;
                    idx_next    = '0;
                    status_next = apq_pkg::STAT_DONE;
                    if (is_enq) begin
                        if (not_full) begin
                            wr_en        = 1'b1;
                            wr_addr      = count_reg[AW-1:0];
                            wr_data.prio = s_priority_req;
                            wr_data.data = s_data_value;
                            count_next   = count_reg + CW'(1);
                        end else begin
                            status_next = apq_pkg::STAT_FULL;
                        end
                    end else if (count_reg == '0) begin
                        status_next = apq_pkg::STAT_EMPTY;
                    end
                end
            end
            apq_pkg::ST_SCAN: begin
                // data of entry idx-1 arrives while idx is read
                if (idx_reg != '0) begin
                    if (idx_reg == CW'(1) || rd_data.prio > best_reg.prio) begin
                        best_idx_next = AW'(idx_reg - CW'(1));
                        best_next     = rd_data;
                    end
                end
                idx_next = idx_reg + CW'(1);
                sh_next  = CW'(best_idx_next) + CW'(1);
            end
            apq_pkg::ST_SHIFT: begin
                rd_addr = sh_reg[AW-1:0];
                // word read last cycle goes one place down
                wr_en   = pend_reg;
                if (sh_issue) begin
                    pend_next  = 1'b1;
                    waddr_next = AW'(sh_reg - CW'(1));
                    sh_next    = sh_reg + CW'(1);
                end
                if (shift_done) begin
                    count_next = count_reg - CW'(1);
                end
            end
            apq_pkg::ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apq_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        sh_reg       <= sh_next;
        waddr_reg    <= waddr_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_data_reg   <= best_reg.data;
            m_prio_reg   <= best_reg.prio;
            m_occ_reg    <= apq_pkg::OCC_W'(count_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_data     = m_data_reg;
    assign m_out_priority = m_prio_reg;
    assign m_occupancy    = m_occ_reg;

    `APQ_ASSERT(a_count_bound, count_reg <= CW'(apq_pkg::DEPTH), "entry count above depth")
    `APQ_ASSERT(a_no_write_in_scan, state_reg == apq_pkg::ST_SCAN |-> !wr_en,
        "ram written during scan")
    `APQ_ASSERT(a_write_in_range, wr_en |-> CW'(wr_addr) < count_reg + CW'(1),
        "ram write beyond held entries")
    `APQ_ASSERT(a_enq_count, accept && is_enq && not_full |=>
        count_reg == $past(count_reg) + CW'(1), "enqueue did not grow count")
    `APQ_ASSERT(a_deq_scan, accept && !is_enq && count_reg != '0 |=>
        state_reg == apq_pkg::ST_SCAN, "dequeue did not start scan")

endmodule
